// File: hdl/npps_pkg.sv
package npps_pkg;

    // Default table depth
    localparam int MAX_PROCESSES_DEF = 16;

    // Fixed field widths
    localparam int ARR_W     = 16;
    localparam int BURST_W   = 16;
    localparam int PRIO_W    = 8;
    localparam int PIDX_W    = 4;
    localparam int OTIME_W   = 21;

    // Results emitted per set at most
    localparam int RESULT_LIMIT = 16;
    localparam int EMIT_W       = 5;

    // Stream word widths (padded to bytes)
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

    // One stored process
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [ARR_W-1:0]   arrival;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: hdl/npps_ram.sv
module npps_ram import npps_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = MAX_PROCESSES_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/npps_scan.sv
module npps_scan import npps_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
    parameter int IDX_W         = $clog2(MAX_PROCESSES),
    parameter int TIME_W        = 21
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clr,
    input  logic              vld,
    input  logic [IDX_W-1:0]  idx,
    input  entry_t            ent,
    input  logic              done,
    input  logic [TIME_W-1:0] cur_time,
    output logic              found,
    output logic [IDX_W-1:0]  best_idx,
    output entry_t            best,
    output logic [ARR_W-1:0]  min_arr
);

    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    entry_t            best_reg;
    logic [ARR_W-1:0]  min_arr_reg;
    logic              ready;
    logic              take;

    // Entry has arrived and is unfinished
    assign ready = !done && (TIME_W'(ent.arrival) <= cur_time);
    // Strictly higher priority replaces, so the lowest index wins ties
    assign take  = ready && (!found_reg || (ent.prio > best_reg.prio));

    // Running best and earliest pending arrival
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            min_arr_reg <= '1;
        end
        else if (clr)
        begin
            found_reg   <= 1'b0;
            min_arr_reg <= '1;
        end
        else if (vld)
        begin
            if (take)
            begin
                found_reg <= 1'b1;
            end
            if (!done && (ent.arrival < min_arr_reg))
            begin
                min_arr_reg <= ent.arrival;
            end
        end
    end

    // Payload of the best candidate
    always_ff @(posedge clk)
    begin
        if (vld && !clr && take)
        begin
            best_idx_reg <= idx;
            best_reg     <= ent;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best     = best_reg;
    assign min_arr  = min_arr_reg;

endmodule

// File: hdl/nonpreemptive_priority_scheduler.sv
// Non-preemptive priority scheduler.
// Load: one word per cycle, no result until the word marked tlast.
// Per result: one pass over the process RAM at one read per cycle through the registered read
// pipeline, then pick, difference and output; an idle processor adds a further pass
// that jumps time to the earliest pending arrival.
// Reset clears counters, done flags and the output register; the RAM is not cleared.
module nonpreemptive_priority_scheduler import npps_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // arrival_time[15:0], burst_length[31:16], priority_level[39:32]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // process_index[3:0], completion_time[24:4], waiting_time[45:25],
    // turnaround_time[66:46]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    localparam int IDX_W  = $clog2(MAX_PROCESSES);
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int TIME_W = $clog2((MAX_PROCESSES + 1) * (1 << ARR_W));

    typedef enum logic [2:0] {ST_LOAD, ST_SCAN, ST_PICK, ST_CALC, ST_EMIT} state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          loaded_reg;
    logic [CNT_W-1:0]          finished_reg;
    logic [CNT_W-1:0]          issue_reg;
    logic [EMIT_W-1:0]         emit_reg;
    logic [TIME_W-1:0]         time_reg;
    logic [TIME_W-1:0]         turn_reg;
    logic [MAX_PROCESSES-1:0]  done_reg;
    logic                      rd_valid_reg;
    logic [IDX_W-1:0]          rd_idx_reg;
    logic                      m_tvalid_reg;
    logic                      m_tlast_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;

    logic                      in_acc;
    logic                      wr_en;
    entry_t                    wr_ent;
    entry_t                    rd_ent;
    logic [ENTRY_W-1:0]        rd_word;
    logic [IDX_W-1:0]          rd_addr;
    logic                      issue;
    logic                      scan_clr;
    logic                      found;
    logic [IDX_W-1:0]          best_idx;
    entry_t                    best;
    logic [ARR_W-1:0]          min_arr;
    logic                      slot_free;
    logic                      emit_go;
    logic                      is_last;
    logic [TIME_W-1:0]         wait_time;

    // Input side
    assign s_tready = (state_reg == ST_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign wr_en    = in_acc && (loaded_reg < CNT_W'(MAX_PROCESSES));
    assign wr_ent   = entry_t'(s_tdata[ENTRY_W-1:0]);

    // Scan read issue
    assign issue    = (state_reg == ST_SCAN) && (issue_reg < loaded_reg);
    assign rd_addr  = issue_reg[IDX_W-1:0];
    assign scan_clr = (state_reg == ST_SCAN) && (issue_reg == '0);
    assign rd_ent   = entry_t'(rd_word);

    npps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCESSES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (loaded_reg[IDX_W-1:0]),
        .wdata (wr_ent),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    npps_scan #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .IDX_W         (IDX_W),
        .TIME_W        (TIME_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (scan_clr),
        .vld      (rd_valid_reg),
        .idx      (rd_idx_reg),
        .ent      (rd_ent),
        .done     (done_reg[rd_idx_reg]),
        .cur_time (time_reg),
        .found    (found),
        .best_idx (best_idx),
        .best     (best),
        .min_arr  (min_arr)
    );

    // Output slot and result fields
    assign slot_free = !m_tvalid_reg || m_tready;
    assign emit_go   = (state_reg == ST_EMIT) && slot_free;
    assign is_last   = (finished_reg == loaded_reg) ||
                       (emit_reg == EMIT_W'(RESULT_LIMIT - 1));
    assign wait_time = turn_reg - TIME_W'(best.burst);

    // Sequencer, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            loaded_reg   <= '0;
            finished_reg <= '0;
            issue_reg    <= '0;
            emit_reg     <= '0;
            time_reg     <= '0;
            turn_reg     <= '0;
            done_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (m_tready && !emit_go)
            begin
                m_tvalid_reg <= 1'b0;
            end
            rd_valid_reg <= issue;
            rd_idx_reg   <= rd_addr;
            if (issue)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (wr_en)
                        begin
                            loaded_reg <= loaded_reg + CNT_W'(1);
                        end
                        if (s_tlast)
                        begin
                            time_reg  <= '0;
                            issue_reg <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (!issue && !rd_valid_reg && (issue_reg == loaded_reg))
                    begin
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    issue_reg <= '0;
                    if (found)
                    begin
                        time_reg           <= time_reg + TIME_W'(best.burst);
                        done_reg[best_idx] <= 1'b1;
                        finished_reg       <= finished_reg + CNT_W'(1);
                        state_reg          <= ST_CALC;
                    end
                    else
                    begin
                        // Idle: jump to the earliest pending arrival
                        time_reg  <= TIME_W'(min_arr);
                        state_reg <= ST_SCAN;
                    end
                end
                ST_CALC:
                begin
                    turn_reg  <= time_reg - TIME_W'(best.arrival);
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= is_last;
                        m_tdata_reg  <= {5'b0, OTIME_W'(turn_reg), OTIME_W'(wait_time),
                                         OTIME_W'(time_reg), PIDX_W'(best_idx)};
                        issue_reg    <= '0;
                        if (is_last)
                        begin
                            loaded_reg   <= '0;
                            finished_reg <= '0;
                            emit_reg     <= '0;
                            time_reg     <= '0;
                            done_reg     <= '0;
                            state_reg    <= ST_LOAD;
                        end
                        else
                        begin
                            emit_reg  <= emit_reg + EMIT_W'(1);
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

    // Finished processes never exceed the loaded set
    a_fin_le_load: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg <= loaded_reg)
        else $error("finished count exceeds loaded count");

    // A pass with no ready process only happens with work still pending
    a_idle_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) && !found |-> finished_reg < loaded_reg)
        else $error("idle pass with all processes finished");

    // Loading starts from a cleared schedule
    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (finished_reg == '0) && (emit_reg == '0))
        else $error("schedule state not cleared while loading");

    // Emission count stays within the result limit
    a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg < EMIT_W'(RESULT_LIMIT))
        else $error("result count out of range");

endmodule

// File: test/nonpreemptive_priority_scheduler_tb.sv
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler_tb;
    import npps_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_WORDS = 300;

    // One scheduled process as it leaves the block
    typedef struct packed {
        logic [PIDX_W-1:0]  idx;
        logic [OTIME_W-1:0] finish;
        logic [OTIME_W-1:0] idle_wait;
        logic [OTIME_W-1:0] turn;
        logic               tail;
    } sched_rec_t;

    // Directed stimulus row; typed rows are single-process sets
    typedef struct {
        bit [ARR_W-1:0]   arr;
        bit [BURST_W-1:0] burst;
        bit [PRIO_W-1:0]  prio;
        bit               tail;
        bit               typed;
        int               finish;
        int               idle_wait;
        int               turn;
    } probe_row_t;

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;

    // Shadow process table
    int arr_tab [MAX_PROCESSES_DEF];
    int burst_tab [MAX_PROCESSES_DEF];
    int prio_tab [MAX_PROCESSES_DEF];
    int load_cnt = 0;

    sched_rec_t pending_sched[$];
    int err_count = 0;
    int words_in = 0;
    int results_seen = 0;
    int sets_done = 0;
    int overflow_sets = 0;
    int stall_cycles = 0;
    int src_idle_pct = 29;
    int sink_idle_pct = 83;

    probe_row_t probe_rows [22];

    nonpreemptive_priority_scheduler u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 100 MHz clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Store one process; on the set's last word, run the whole schedule
    function automatic void plan_schedule(input logic [ARR_W-1:0] arr,
                                          input logic [BURST_W-1:0] burst,
                                          input logic [PRIO_W-1:0] prio,
                                          input logic tail,
                                          output sched_rec_t recs[$]);
        bit         finished [MAX_PROCESSES_DEF];
        int         best;
        int         fin;
        int         now_tick;
        int         earliest;
        int         turn_v;
        sched_rec_t rec;
        recs = {};
        if (load_cnt < MAX_PROCESSES_DEF)
        begin
            arr_tab[load_cnt] = arr;
            burst_tab[load_cnt] = burst;
            prio_tab[load_cnt] = prio;
            load_cnt++;
        end
        if (!tail)
            return;
        foreach (finished[i])
            finished[i] = 1'b0;
        now_tick = 0;
        fin = 0;
        while (fin < load_cnt)
        begin
            best = -1;
            earliest = 32'h7FFF_FFFF;
            for (int i = 0; i < load_cnt; i++)
            begin
                if (finished[i])
                    continue;
                if (arr_tab[i] > now_tick)
                begin
                    if (arr_tab[i] < earliest)
                        earliest = arr_tab[i];
                    continue;
                end
                if (best < 0 || prio_tab[i] > prio_tab[best])
                    best = i;
            end
            // idle processor: ticking one at a time lands on the earliest arrival
            if (best < 0)
            begin
                now_tick = earliest;
                continue;
            end
            now_tick += burst_tab[best];
            finished[best] = 1'b1;
            fin++;
            turn_v = now_tick - arr_tab[best];
            rec.idx = best[PIDX_W-1:0];
            rec.finish = now_tick[OTIME_W-1:0];
            rec.turn = turn_v[OTIME_W-1:0];
            rec.idle_wait = OTIME_W'(turn_v - burst_tab[best]);
            rec.tail = (fin == load_cnt);
            if (recs.size() < RESULT_LIMIT)
                recs.push_back(rec);
        end
        if (recs.size() > 0)
            recs[recs.size()-1].tail = 1'b1;
        load_cnt = 0;
    endfunction

    // Send one word with a random lead-in gap; returns what it schedules
    task automatic push_word(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                             input logic [PRIO_W-1:0] prio, input logic tail,
                             output sched_rec_t recs[$]);
        int gaps;
        gaps = 0;
        while ($urandom_range(99) < src_idle_pct)
            gaps++;
        if (gaps > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        s_tdata <= {prio, burst, arr};
        s_tlast <= tail;
        s_tvalid <= 1'b1;
        do
            @(negedge clk);
        while (!s_tready);
        plan_schedule(arr, burst, prio, tail, recs);
        words_in++;
        if (tail)
            sets_done++;
        @(posedge clk);
    endtask

    // Sender pauses until every scheduled result has come out
    task automatic hold_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_sched.size() != 0)
            @(posedge clk);
    endtask

    function automatic void note_diff(input string what, input int want, input int got);
        if (want != got)
        begin
            err_count++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endfunction

    // Receiver backpressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    // Result checker and watchdog, sampled mid-cycle
    always @(negedge clk)
    begin
        sched_rec_t got;
        sched_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.idx = m_tdata[3:0];
            got.finish = m_tdata[24:4];
            got.idle_wait = m_tdata[45:25];
            got.turn = m_tdata[66:46];
            got.tail = m_tlast;
            results_seen++;
            if (pending_sched.size() == 0)
            begin
                err_count++;
                $display("%0t: expected no word, got index %0d completion %0d",
                         $time, got.idx, got.finish);
            end
            else
            begin
                want = pending_sched.pop_front();
                note_diff("process_index", want.idx, got.idx);
                note_diff("completion_time", want.finish, got.finish);
                note_diff("waiting_time", want.idle_wait, got.idle_wait);
                note_diff("turnaround_time", want.turn, got.turn);
                note_diff("last_result", want.tail, got.tail);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        sched_rec_t recs[$];
        sched_rec_t rec;
        int phase;
        int rand_words;
        int set_len;
        int arr_span;
        int burst_span;
        int prio_span;
        int pick;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;

        // single sets with obvious results, a full table plus one dropped word,
        // and a tie with an idle gap before the last arrival
        probe_rows = '{
            '{16'h0000, 16'h0001, 8'h00, 1'b1, 1'b1, 1, 0, 1},
            '{16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 131070, 0, 65535},
            '{16'd5,      16'd3,      8'd10,  1'b0, 1'b0, 0, 0, 0},
            '{16'd0,      16'd2,      8'd10,  1'b0, 1'b0, 0, 0, 0},
            '{16'd0,      16'd7,      8'd200, 1'b0, 1'b0, 0, 0, 0},
            '{16'd3,      16'd1,      8'd200, 1'b0, 1'b0, 0, 0, 0},
            '{16'd40,     16'd4,      8'd0,   1'b0, 1'b0, 0, 0, 0},
            '{16'd2,      16'd9,      8'd255, 1'b0, 1'b0, 0, 0, 0},
            '{16'd2,      16'd9,      8'd255, 1'b0, 1'b0, 0, 0, 0},
            '{16'd100,    16'd1,      8'd77,  1'b0, 1'b0, 0, 0, 0},
            '{16'd8,      16'h8000,   8'd128, 1'b0, 1'b0, 0, 0, 0},
            '{16'd1,      16'd5,      8'd1,   1'b0, 1'b0, 0, 0, 0},
            '{16'd0,      16'd1,      8'd254, 1'b0, 1'b0, 0, 0, 0},
            '{16'h7FFF,   16'd2,      8'd3,   1'b0, 1'b0, 0, 0, 0},
            '{16'd20,     16'd6,      8'd10,  1'b0, 1'b0, 0, 0, 0},
            '{16'd12,     16'd1,      8'd0,   1'b0, 1'b0, 0, 0, 0},
            '{16'd6,      16'd2,      8'd99,  1'b0, 1'b0, 0, 0, 0},
            '{16'd0,      16'd3,      8'd42,  1'b0, 1'b0, 0, 0, 0},
            '{16'd0,      16'd1,      8'd255, 1'b1, 1'b0, 0, 0, 0},
            '{16'd10,     16'd2,      8'd5,   1'b0, 1'b0, 0, 0, 0},
            '{16'd10,     16'd3,      8'd5,   1'b0, 1'b0, 0, 0, 0},
            '{16'd30,     16'd1,      8'd9,   1'b1, 1'b0, 0, 0, 0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (probe_rows[k])
        begin
            push_word(probe_rows[k].arr, probe_rows[k].burst, probe_rows[k].prio,
                      probe_rows[k].tail, recs);
            if (probe_rows[k].typed)
            begin
                rec.idx = '0;
                rec.finish = probe_rows[k].finish[OTIME_W-1:0];
                rec.idle_wait = probe_rows[k].idle_wait[OTIME_W-1:0];
                rec.turn = probe_rows[k].turn[OTIME_W-1:0];
                rec.tail = 1'b1;
                pending_sched.push_back(rec);
            end
            else
                foreach (recs[j])
                    pending_sched.push_back(recs[j]);
        end
        overflow_sets++;
        hold_sender();

        // random sets; idling mix changes by thirds
        phase = 0;
        rand_words = 0;
        while (rand_words < RANDOM_WORDS)
        begin
            if (phase == 0 && rand_words >= RANDOM_WORDS / 3)
            begin
                phase = 1;
                hold_sender();
                src_idle_pct = 83;
                sink_idle_pct = 29;
            end
            else if (phase == 1 && rand_words >= 2 * RANDOM_WORDS / 3)
            begin
                phase = 2;
                hold_sender();
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 70)
                set_len = $urandom_range(6, 1);
            else if (pick < 90)
                set_len = $urandom_range(16, 7);
            else
                set_len = $urandom_range(18, 17);
            if (set_len > MAX_PROCESSES_DEF)
                overflow_sets++;
            // mostly dense arrivals and short bursts so processes contend
            arr_span = ($urandom_range(99) < 80) ? 40 : 65535;
            burst_span = ($urandom_range(99) < 75) ? 24 : 65535;
            prio_span = ($urandom_range(99) < 40) ? 3 : 255;
            for (int n = 0; n < set_len; n++)
            begin
                push_word(ARR_W'($urandom_range(arr_span, 0)),
                          BURST_W'($urandom_range(burst_span, 1)),
                          PRIO_W'($urandom_range(prio_span, 0)),
                          n == set_len - 1, recs);
                foreach (recs[j])
                    pending_sched.push_back(recs[j]);
            end
            rand_words += set_len;
        end

        // drain, then watch for stray words
        hold_sender();
        repeat (200) @(posedge clk);

        $display("Sent %0d words in %0d sets (%0d overflowing the table), checked %0d results,",
                 words_in, sets_done, overflow_sets, results_seen);
        $display("under three idle/backpressure mixes including a no-idle stretch.");
        if (err_count == 0 && pending_sched.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
